@@ rtl/core/mcf_pkg.sv @@
// Shared types, constants and median network helpers for the 3x3 median filter.
package mcf_pkg;

    // Configuration register indexes
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_SLICE_ROWS = 1'b1;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // What a queued column does at the back end
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_MEDIAN,
        EMIT_MEDIAN_CLOSE
    } emit_t;

    // One 3-pixel column: top in [7:0], middle in [15:8], bottom in [23:16]
    typedef logic [23:0] column_t;

    typedef struct packed {
        column_t col0;
        column_t col1;
        column_t col2;
        emit_t   mode;
        logic    last_row;
    } work_t;

    typedef logic [8:0][7:0] window9_t;

    // Median compare-exchange network, pair order matters
    localparam int NET_PAIRS = 19;
    localparam logic [3:0] NET_A [NET_PAIRS] = '{
        4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7,
        4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
    };
    localparam logic [3:0] NET_B [NET_PAIRS] = '{
        4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8,
        4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
    };

    // Split three columns into nine pixels
    function automatic window9_t unpack_window(column_t c0, column_t c1, column_t c2);
        window9_t p;
        p[0] = c0[7:0];
        p[1] = c0[15:8];
        p[2] = c0[23:16];
        p[3] = c1[7:0];
        p[4] = c1[15:8];
        p[5] = c1[23:16];
        p[6] = c2[7:0];
        p[7] = c2[15:8];
        p[8] = c2[23:16];
        return p;
    endfunction

    // Apply network pairs first..last: smaller value goes to the A slot
    function automatic window9_t cx_span(window9_t p_in, int first, int last);
        window9_t     p;
        logic [7:0]   x;
        logic [7:0]   y;
        p = p_in;
        for (int i = 0; i < NET_PAIRS; i++)
        begin
            if (i >= first && i <= last)
            begin
                x = p[NET_A[i]];
                y = p[NET_B[i]];
                if (x > y)
                begin
                    p[NET_A[i]] = y;
                    p[NET_B[i]] = x;
                end
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/core/mcf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mcf_front.sv @@
// Front end: pixel intake, row/column tracking, line stores, window and classification.
module mcf_front
    import mcf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [7:0]         pixel,
    input  logic [10:0]        line_width,
    input  logic [11:0]        slice_rows,
    input  logic [LEVEL_W-1:0] q_level,
    output logic               push,
    output work_t              push_item
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = (AW + 1 > 11) ? AW + 1 : 11;

    logic [AW-1:0] column_count_reg, column_count_next;
    logic [12:0]   row_count_reg, row_count_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [7:0]    s1_pixel_reg;
    logic [AW-1:0] s1_col_reg;
    emit_t         s1_mode_reg;
    logic          s1_last_row_reg;

    column_t       win0_reg, win1_reg;

    logic [XW-1:0] width_ext;
    logic [XW-1:0] width_eff;
    logic [12:0]   rows_eff;
    logic          last_col;
    logic          last_row;
    logic          accept;
    emit_t         mode;
    logic [15:0]   line_rd;
    column_t       col_now;

    // Clamp configuration to its working range
    always_comb
    begin
        width_ext = XW'(line_width);
        if (width_ext < XW'(3))
        begin
            width_eff = XW'(3);
        end
        else if (width_ext > XW'(MAX_WIDTH))
        begin
            width_eff = XW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        rows_eff = (slice_rows == 12'd0) ? 13'd1 : {1'b0, slice_rows};
    end

    assign last_col = (XW'(column_count_reg) + XW'(1)) >= width_eff;
    assign last_row = row_count_reg >= (rows_eff + 13'd1);

    // Hold intake while the queue could overflow
    assign pixel_stall = ((LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(s1_valid_reg))
                         >= (LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept = pixel_valid && !pixel_stall;

    // Classify the pixel by its place in the slice
    always_comb
    begin
        mode = EMIT_NONE;
        if (row_count_reg >= 13'd2)
        begin
            if (column_count_reg == '0)
            begin
                mode = EMIT_ZERO;
            end
            else if (column_count_reg >= AW'(2))
            begin
                mode = last_col ? EMIT_MEDIAN_CLOSE : EMIT_MEDIAN;
            end
        end
    end

    // Advance column and row counters
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? 13'd0 : row_count_reg + 13'd1;
            end
            else
            begin
                column_count_next = column_count_reg + AW'(1);
            end
        end
    end

    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    // Capture pixel context while the line stores are read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= column_count_reg;
            s1_mode_reg     <= mode;
            s1_last_row_reg <= last_row;
        end
    end

    // Line stores: older row in [7:0], newer row in [15:8]
    mcf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_pixel_reg, line_rd[15:8]}),
        .rd_en   (accept),
        .rd_addr (column_count_reg),
        .rd_data (line_rd)
    );

    assign col_now = {s1_pixel_reg, line_rd[15:8], line_rd[7:0]};

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win0_reg <= win1_reg;
            win1_reg <= col_now;
        end
    end

    // Hand work to the back end
    assign push                = s1_valid_reg && (s1_mode_reg != EMIT_NONE);
    assign push_item.col0      = win0_reg;
    assign push_item.col1      = win1_reg;
    assign push_item.col2      = col_now;
    assign push_item.mode      = s1_mode_reg;
    assign push_item.last_row  = s1_last_row_reg;

endmodule

@@ rtl/core/mcf_queue.sv @@
// Short work queue between the front and back ends.
module mcf_queue
    import mcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  work_t              push_item,
    input  logic               pop,
    output work_t              head,
    output logic               not_empty,
    output logic [LEVEL_W-1:0] level
);

    work_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               do_pop;

    assign do_pop = pop && (level_reg != '0);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, do_pop})
            2'b10:   level_next = level_reg + LEVEL_W'(1);
            2'b01:   level_next = level_reg - LEVEL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head      = q_mem_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

@@ rtl/core/mcf_back.sv @@
// Back end: pipelined median network and result emission with output register.
module mcf_back
    import mcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  work_t      item,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] value,
    output logic       end_of_row,
    output logic       end_of_slice
);

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    window9_t   s1_p_reg, s2_p_reg;
    logic [7:0] s3_med_reg;
    emit_t      s1_mode_reg, s2_mode_reg, s3_mode_reg;
    logic       s1_last_reg, s2_last_reg, s3_last_reg;
    logic       s3_close_reg, s3_close_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_value_reg;
    logic       out_eor_reg, out_eos_reg;

    logic       out_free;
    logic       emit;
    logic       s3_done;
    logic       s3_take, s2_take, s1_take;
    logic [7:0] emit_value;
    logic       emit_eor, emit_eos;
    window9_t   s3_p;

    assign out_free = !out_valid_reg || !result_stall;

    // Pick the result shown by the last stage
    always_comb
    begin
        emit          = 1'b0;
        s3_done       = 1'b0;
        s3_close_next = s3_close_reg;
        emit_value    = 8'd0;
        emit_eor      = 1'b0;
        emit_eos      = 1'b0;
        if (s3_valid_reg && out_free)
        begin
            emit = 1'b1;
            if (s3_close_reg)
            begin
                emit_eor      = 1'b1;
                emit_eos      = s3_last_reg;
                s3_done       = 1'b1;
                s3_close_next = 1'b0;
            end
            else
            begin
                case (s3_mode_reg)
                    EMIT_MEDIAN_CLOSE:
                    begin
                        emit_value    = s3_med_reg;
                        s3_close_next = 1'b1;
                    end
                    EMIT_MEDIAN:
                    begin
                        emit_value = s3_med_reg;
                        s3_done    = 1'b1;
                    end
                    default:
                    begin
                        s3_done = 1'b1;
                    end
                endcase
            end
        end
    end

    // Stage hand-off: a stage takes new work when empty or draining
    assign s3_take = !s3_valid_reg || s3_done;
    assign s2_take = !s2_valid_reg || s3_take;
    assign s1_take = !s1_valid_reg || s2_take;
    assign pop     = item_valid && s1_take;

    assign s3_p = cx_span(s2_p_reg, 15, 18);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_close_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_take)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            s3_close_reg <= s3_close_next;
        end
    end

    // Median network, split by pairs across the stages: 0-8, then 9-14, then 15-18
    always_ff @(posedge clk)
    begin
        if (s1_take && item_valid)
        begin
            s1_p_reg    <= cx_span(unpack_window(item.col0, item.col1, item.col2), 0, 8);
            s1_mode_reg <= item.mode;
            s1_last_reg <= item.last_row;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_p_reg    <= cx_span(s1_p_reg, 9, 14);
            s2_mode_reg <= s1_mode_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_take && s2_valid_reg)
        begin
            s3_med_reg  <= s3_p[4];
            s3_mode_reg <= s2_mode_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Output register: load on a free slot, hold while stalled
    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= emit_value;
            out_eor_reg   <= emit_eor;
            out_eos_reg   <= emit_eos;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = out_value_reg;
    assign end_of_row   = out_eor_reg;
    assign end_of_slice = out_eos_reg;

endmodule

@@ rtl/core/median_3x3_filter_unit.sv @@
// Top level of the 3x3 median filter: configuration registers and front/queue/back wiring.
//
// Streams one padded slice of 8-bit gray pixels in raster order (a padding row,
// slice_rows image rows, a padding row, each line_width pixels) and returns for each
// output row a 0, the 3x3 median of every inner column, and a closing 0 flagged with
// end_of_row (and end_of_slice on the last row). Sustained rate is one pixel per clock
// while pixel_stall is low: the line stores are one RAM with one read and one write per
// cycle, and the median network is a three-stage pipeline. A row end yields two results
// from one pixel; a four-entry queue absorbs the extra result. An accepted pixel passes
// the capture registers, a queue entry, the three network stages and the output register.
// No clearing pass is needed after reset. Configuration is taken at any time through
// cfg_valid/cfg_ready and must only change while no pixel is in flight.
module median_3x3_filter_unit
    import mcf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  value,
    output logic        end_of_row,
    output logic        end_of_slice
);

    logic [10:0]        line_width_reg;
    logic [11:0]        slice_rows_reg;
    logic               push;
    work_t              push_item;
    work_t              head;
    logic               pop;
    logic               not_empty;
    logic [LEVEL_W-1:0] q_level;

    assign cfg_ready = 1'b1;

    // Write configuration registers on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= 11'd450;
            slice_rows_reg <= 12'd375;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[10:0];
                CFG_SLICE_ROWS: slice_rows_reg <= cfg_data;
                default:        line_width_reg <= line_width_reg;
            endcase
        end
    end

    mcf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .line_width  (line_width_reg),
        .slice_rows  (slice_rows_reg),
        .q_level     (q_level),
        .push        (push),
        .push_item   (push_item)
    );

    mcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .level     (q_level)
    );

    mcf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (not_empty),
        .item         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .end_of_row   (end_of_row),
        .end_of_slice (end_of_slice)
    );

endmodule

@@ tb/sv/median_3x3_filter_unit_tb.sv @@
// Self-checking testbench for the 3x3 median filter: directed and random padded slices against a predictor.
`timescale 1ns / 100ps

module median_3x3_filter_unit_tb;
    import mcf_pkg::*;

    localparam int LINE_MAX  = 1024;
    localparam int SETTLE    = 16;     // wait well past the block latency
    localparam int HOLD_AT   = 300;    // pixel count at which the long output hold starts
    localparam int HOLD_LEN  = 300;
    localparam int RAND_PIX  = 1500;

    typedef struct {
        bit [7:0] value;
        bit       eor;
        bit       eos;
    } px_out_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_index    = 1'b0;
    logic [11:0] cfg_data     = '0;
    logic        pixel_valid  = 1'b0;
    logic        pixel_stall;
    logic [7:0]  pixel        = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  value;
    logic        end_of_row;
    logic        end_of_slice;

    // Predictor state
    bit [7:0]  line_old [LINE_MAX];
    bit [7:0]  line_new [LINE_MAX];
    bit [23:0] win_col  [2];
    int        col_pos;
    int        row_pos;
    bit [10:0] width_reg;
    bit [11:0] rows_reg;

    bit [7:0]  pixel_q [$];
    px_out_t   filtered_due [$];
    int        pix_pushed   = 0;
    int        pix_accepted = 0;
    int        err_count    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    median_3x3_filter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .end_of_row   (end_of_row),
        .end_of_slice (end_of_slice)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < 200)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int eff_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int eff_rows();
        return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    // Median of nine pixels by plain insertion sort
    function automatic bit [7:0] median_of(bit [23:0] a, bit [23:0] b, bit [23:0] d);
        bit [7:0]  v [9];
        bit [7:0]  t;
        bit [71:0] all;
        int        j;
        all = {d, b, a};
        for (int i = 0; i < 9; i++)
            v[i] = all[i*8 +: 8];
        for (int i = 1; i < 9; i++)
        begin
            t = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > t)
            begin
                v[j+1] = v[j];
                j--;
            end
            v[j+1] = t;
        end
        return v[4];
    endfunction

    // Advance the predictor by one pixel and queue the filtered outputs it causes
    function automatic void filter_pixel(bit [7:0] pix);
        int        w;
        int        rows;
        int        c;
        bit        last_c;
        bit        last_r;
        bit [23:0] col;
        w    = eff_width();
        rows = eff_rows();
        c    = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        last_c = (c >= w - 1);
        last_r = (row_pos >= rows + 1);
        col = {pix, line_new[c], line_old[c]};
        if (row_pos >= 2)
        begin
            if (c == 0)
                filtered_due.push_back('{8'd0, 1'b0, 1'b0});
            else if (c >= 2)
            begin
                filtered_due.push_back('{median_of(win_col[0], win_col[1], col), 1'b0, 1'b0});
                if (last_c)
                    filtered_due.push_back('{8'd0, 1'b1, last_r});
            end
        end
        line_old[c] = line_new[c];
        line_new[c] = pix;
        win_col[0]  = win_col[1];
        win_col[1]  = col;
        if (last_c)
        begin
            col_pos = 0;
            row_pos = last_r ? 0 : row_pos + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    // Pixels still needed to close the slice in progress
    function automatic int pixels_left();
        int w;
        int rows;
        int c;
        int rest;
        int rows_after;
        w    = eff_width();
        rows = eff_rows();
        c    = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        rest = (c >= w - 1) ? 1 : w - c;
        rows_after = (row_pos >= rows + 1) ? 0 : rows + 1 - row_pos;
        return rest + rows_after * w;
    endfunction

    function automatic bit [7:0] pick_pixel(int style, bit [7:0] base);
        case (style)
            0:       return 8'($urandom_range(255));
            1:       return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return base + 8'($urandom_range(3));
        endcase
    endfunction

    task automatic queue_pixels(int n, int style, bit [7:0] base);
        for (int i = 0; i < n; i++)
        begin
            pixel_q.push_back(pick_pixel(style, base));
            pix_pushed++;
        end
    endtask

    // Write one register through the config channel, then mirror it in the predictor
    task automatic write_filter_reg(logic idx, logic [11:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LINE_WIDTH)
            width_reg = data[10:0];
        else
            rows_reg = data;
    endtask

    task automatic write_width(int raw);
        write_filter_reg(CFG_LINE_WIDTH, {1'($urandom_range(1)), 11'(raw)});
    endtask

    // Wait until every pixel has transferred and every output has arrived
    task automatic wait_drained();
        while (pix_accepted != pix_pushed || filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Driver: offer queued pixels, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin : drv_blk
        logic offer;
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel       <= '0;
        end
        else
        begin
            offer = pixel_valid;
            if (pixel_valid && !pixel_stall)
            begin
                filter_pixel(pixel);
                pix_accepted++;
                offer = 1'b0;
            end
            if (!offer && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel <= pixel_q.pop_front();
                offer = 1'b1;
            end
            pixel_valid <= offer;
        end
    end

    // Monitor: check each output transfer against the oldest due output
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        px_out_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (filtered_due.size() == 0)
                    report_mismatch("output with none due, value", value, 0);
                else
                begin
                    want = filtered_due.pop_front();
                    if (value != want.value)
                        report_mismatch("value", value, want.value);
                    if (end_of_row != want.eor)
                        report_mismatch("end_of_row", end_of_row, want.eor);
                    if (end_of_slice != want.eos)
                        report_mismatch("end_of_slice", end_of_slice, want.eos);
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Hold the output side off once for a long stretch so the input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && pix_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin : stim
        int       rand_sent;
        int       sel;
        int       full;
        int       style;
        int       cur;
        bit [7:0] base;

        rand_sent = 0;
        col_pos   = 0;
        row_pos   = 0;
        win_col[0] = '0;
        win_col[1] = '0;
        width_reg = 11'd450;
        rows_reg  = 12'd375;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            line_old[i] = '0;
            line_new[i] = '0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 72;

        // Smallest slice, pixels at both extremes
        write_filter_reg(CFG_LINE_WIDTH, 12'd3);
        write_filter_reg(CFG_SLICE_ROWS, 12'd1);
        pixel_q.push_back(8'd0);   pixel_q.push_back(8'd255); pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255); pixel_q.push_back(8'd255); pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd0);   pixel_q.push_back(8'd255); pixel_q.push_back(8'd255);
        pix_pushed += 9;
        wait_drained();

        // Width below range and zero rows, both act as the minimum
        write_filter_reg(CFG_LINE_WIDTH, 12'h802);
        write_filter_reg(CFG_SLICE_ROWS, 12'd0);
        pixel_q.push_back(8'd255); pixel_q.push_back(8'd255); pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd255); pixel_q.push_back(8'd0);   pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd255); pixel_q.push_back(8'd255); pixel_q.push_back(8'd254);
        pix_pushed += 9;
        wait_drained();

        // Random slices, mostly whole, some cut short by a mid-slice change of width or rows
        while (rand_sent < RAND_PIX)
        begin
            if (rand_sent < RAND_PIX / 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 72;
            end
            else if (rand_sent < 2 * RAND_PIX / 3)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            style = $urandom_range(2);
            base  = 8'($urandom_range(255));
            cur   = pix_pushed;

            if ($urandom_range(24) == 0)
            begin
                // Very wide row, shrunk a little way in
                write_width($urandom_range(1000, 2047));
                write_filter_reg(CFG_SLICE_ROWS, 12'($urandom_range(1, 3)));
                queue_pixels($urandom_range(1, 200), style, base);
                wait_drained();
                write_width($urandom_range(0, 12));
                queue_pixels(pixels_left(), style, base);
                wait_drained();
            end
            else
            begin
                sel = $urandom_range(3);
                if (sel == 0 || sel == 2)
                    write_width(($urandom_range(9) == 0) ? $urandom_range(2)
                                                          : $urandom_range(3, 16));
                if (sel == 1 || sel == 2)
                    write_filter_reg(CFG_SLICE_ROWS,
                                     ($urandom_range(7) == 0) ? 12'd0
                                                              : 12'($urandom_range(1, 4)));
                full = eff_width() * (eff_rows() + 2);
                if ($urandom_range(2) == 0)
                begin
                    // Cut the slice, shrink width and/or change rows, then finish it
                    queue_pixels($urandom_range(1, full - 1), style, base);
                    wait_drained();
                    sel = $urandom_range(2);
                    if (sel != 1)
                        write_width($urandom_range(0, eff_width()));
                    if (sel != 0)
                        write_filter_reg(CFG_SLICE_ROWS, 12'($urandom_range(0, eff_rows() + 1)));
                    queue_pixels(pixels_left(), style, base);
                end
                else
                    queue_pixels(full * $urandom_range(1, 3), style, base);
                wait_drained();
            end
            rand_sent += pix_pushed - cur;
        end

        if (filtered_due.size() != 0)
            report_mismatch("outputs never arrived", 0, filtered_due.size());
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ median_3x3_filter_unit.f @@
rtl/core/mcf_pkg.sv
rtl/core/mcf_ram.sv
rtl/core/mcf_front.sv
rtl/core/mcf_queue.sv
rtl/core/mcf_back.sv
rtl/core/median_3x3_filter_unit.sv
tb/sv/median_3x3_filter_unit_tb.sv
